@@ rtl/pts_pkg.sv @@
// Shared types and codes for the periodic turner sequencer.
package pts_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_FORWARD  = 3'd1,
      MODE_PAUSE    = 3'd2,
      MODE_REVERSE  = 3'd3,
      MODE_DISABLED = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_FORCE  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_INTERVAL = 2'd0,
      CSR_DRIVE    = 2'd1,
      CSR_PAUSE    = 2'd2,
      CSR_DUTY     = 2'd3
   } csr_addr_type;

   // bridge pins: bit 0 pin_a, bit 1 pin_b
   localparam logic [1:0] DIR_OFF = 2'b00;
   localparam logic [1:0] DIR_FWD = 2'b01;
   localparam logic [1:0] DIR_REV = 2'b10;

   localparam logic [31:0] INTERVAL_RESET = 32'd7200000;
   localparam logic [31:0] DRIVE_RESET    = 32'd5000;
   localparam logic [31:0] PAUSE_RESET    = 32'd1000;
   localparam logic [7:0]  DUTY_RESET     = 8'd200;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;

endpackage

@@ rtl/periodic_turner_sequencer.sv @@
// Periodic turner sequencer: timed forward/pause/reverse motor cycle per timestamp item.
// Accepted items pass through the input register, then the result register.
// Throughput: one item per cycle while results are taken; the state update is one subtract and compare per item.
// The input stage advances whenever the result register is empty or being taken.
// Reset (synchronous, active high) returns the mode to idle, clears turn count and times,
// stops the motor and restores the configuration registers to their defaults.
module periodic_turner_sequencer (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // enable[0], now_ms[32:1], zero[39:33]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // pin_a[0], pin_b[1], duty[9:2], mode[12:10],
                                   // running[13], disabled[14], turns_done[30:15],
                                   // last_turn_ms[62:31], zero[63]
);

   // configuration registers
   logic [31:0] interval_ff, drive_ff, pause_ff;
   logic [7:0]  duty_cfg_ff;

   // input stage
   logic        in_valid_ff;
   pts_pkg::cmd_type in_cmd_ff;
   logic        in_en_ff;
   logic [31:0] in_now_ff;

   // sequencer state
   pts_pkg::mode_type mode_ff, mode_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] turn_ff, turn_in;
   logic        was_en_ff, was_en_in;
   logic [1:0]  dir_ff, dir_in;
   logic [7:0]  duty_ff, duty_in;

   // result register
   logic        rsp_valid_ff;
   logic [pts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic advance, fire;

   // step evaluation helpers
   pts_pkg::mode_type m0;
   logic [31:0] s0, l0, since, limit, diff;
   logic        hit;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= pts_pkg::INTERVAL_RESET;
         drive_ff    <= pts_pkg::DRIVE_RESET;
         pause_ff    <= pts_pkg::PAUSE_RESET;
         duty_cfg_ff <= pts_pkg::DUTY_RESET;
      end else if (csr_we) begin
         unique case (pts_pkg::csr_addr_type'(csr_addr))
            pts_pkg::CSR_INTERVAL: interval_ff <= csr_wdata;
            pts_pkg::CSR_DRIVE:    drive_ff    <= csr_wdata;
            pts_pkg::CSR_PAUSE:    pause_ff    <= csr_wdata;
            pts_pkg::CSR_DUTY:     duty_cfg_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= pts_pkg::cmd_type'(req_tuser);
         in_en_ff  <= req_tdata[0];
         in_now_ff <= req_tdata[32:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pts_pkg::MODE_IDLE;
         last_ff   <= '0;
         start_ff  <= '0;
         turn_ff   <= '0;
         was_en_ff <= 1'b0;
         dir_ff    <= pts_pkg::DIR_OFF;
         duty_ff   <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         last_ff   <= last_in;
         start_ff  <= start_in;
         turn_ff   <= turn_in;
         was_en_ff <= was_en_in;
         dir_ff    <= dir_in;
         duty_ff   <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // enable-high update: leave disabled, restart the interval on a fresh enable
   always_comb begin
      m0 = (mode_ff == pts_pkg::MODE_DISABLED) ? pts_pkg::MODE_IDLE : mode_ff;
      s0 = (mode_ff == pts_pkg::MODE_DISABLED) ? in_now_ff : start_ff;
      l0 = ((mode_ff == pts_pkg::MODE_DISABLED) || !was_en_ff) ? in_now_ff : last_ff;
      since = (m0 == pts_pkg::MODE_IDLE) ? l0 : s0;
      case (m0)
         pts_pkg::MODE_IDLE:  limit = interval_ff;
         pts_pkg::MODE_PAUSE: limit = pause_ff;
         default:             limit = drive_ff;
      endcase
      diff = in_now_ff - since;
      hit  = (diff >= limit);
   end

   always_comb begin
      mode_in   = mode_ff;
      last_in   = last_ff;
      start_in  = start_ff;
      turn_in   = turn_ff;
      was_en_in = was_en_ff;
      dir_in    = dir_ff;
      duty_in   = duty_ff;
      unique case (in_cmd_ff)
         pts_pkg::CMD_UPDATE: begin
            if (!in_en_ff) begin
               if (mode_ff != pts_pkg::MODE_DISABLED) begin
                  mode_in  = pts_pkg::MODE_DISABLED;
                  start_in = in_now_ff;
                  dir_in   = pts_pkg::DIR_OFF;
                  duty_in  = '0;
               end
               was_en_in = 1'b0;
            end else begin
               was_en_in = 1'b1;
               mode_in   = m0;
               start_in  = s0;
               last_in   = l0;
               if (hit) begin
                  start_in = in_now_ff;
                  unique case (m0)
                     pts_pkg::MODE_IDLE: begin
                        mode_in = pts_pkg::MODE_FORWARD;
                        dir_in  = pts_pkg::DIR_FWD;
                        duty_in = duty_cfg_ff;
                     end
                     pts_pkg::MODE_FORWARD: begin
                        mode_in = pts_pkg::MODE_PAUSE;
                        dir_in  = pts_pkg::DIR_OFF;
                        duty_in = '0;
                     end
                     pts_pkg::MODE_PAUSE: begin
                        mode_in = pts_pkg::MODE_REVERSE;
                        dir_in  = pts_pkg::DIR_REV;
                        duty_in = duty_cfg_ff;
                     end
                     pts_pkg::MODE_REVERSE: begin
                        mode_in = pts_pkg::MODE_IDLE;
                        dir_in  = pts_pkg::DIR_OFF;
                        duty_in = '0;
                        last_in = in_now_ff;
                        turn_in = turn_ff + 16'd1;
                     end
                     default: start_in = s0;
                  endcase
               end
            end
         end
         pts_pkg::CMD_STOP: begin
            mode_in  = pts_pkg::MODE_IDLE;
            start_in = in_now_ff;
            dir_in   = pts_pkg::DIR_OFF;
            duty_in  = '0;
         end
         pts_pkg::CMD_FORCE: begin
            mode_in  = pts_pkg::MODE_DISABLED;
            start_in = in_now_ff;
            dir_in   = pts_pkg::DIR_OFF;
            duty_in  = '0;
         end
         default: ;
      endcase

      rsp_data_in = {1'b0, last_in, turn_in,
                     (mode_in == pts_pkg::MODE_DISABLED),
                     (mode_in == pts_pkg::MODE_FORWARD) || (mode_in == pts_pkg::MODE_REVERSE),
                     mode_in, duty_in, dir_in[1], dir_in[0]};
   end

   // bridge pins follow the mode
   a_pins_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != pts_pkg::MODE_FORWARD && mode_ff != pts_pkg::MODE_REVERSE)
         |-> (dir_ff == pts_pkg::DIR_OFF && duty_ff == 8'd0))
      else $error("motor driven outside a drive step");

   a_pins_fwd: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == pts_pkg::MODE_FORWARD) |-> (dir_ff == pts_pkg::DIR_FWD))
      else $error("forward step without forward pin");

   a_pins_rev: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == pts_pkg::MODE_REVERSE) |-> (dir_ff == pts_pkg::DIR_REV))
      else $error("reverse step without reverse pin");

   // the turn count moves only on reverse -> idle, by one
   a_turn_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && turn_ff != $past(turn_ff))
         |-> ($past(mode_ff) == pts_pkg::MODE_REVERSE && mode_ff == pts_pkg::MODE_IDLE
              && turn_ff == $past(turn_ff) + 16'd1))
      else $error("turn count changed outside a completed turn");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the periodic turner sequencer: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;

   localparam int ITEMS_PER_PHASE = 130;
   localparam int HOLD_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      logic              pin_a;
      logic              pin_b;
      logic [7:0]        duty;
      pts_pkg::mode_type mode;
      logic              running;
      logic              disabled;
      logic [15:0]       turns;
      logic [31:0]       last_turn;
   } status_type;

   typedef struct packed {
      logic                  is_csr;
      pts_pkg::csr_addr_type addr;
      logic [31:0]           value;
      pts_pkg::cmd_type      cmd;
      logic                  en;
      logic [31:0]           now;
      logic                  fixed;
      status_type            want;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = pts_pkg::CSR_INTERVAL;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // enable[0], now_ms[32:1], zero[39:33]
   logic [1:0]  req_tuser = pts_pkg::CMD_UPDATE;  // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;  // pin_a[0], pin_b[1], duty[9:2], mode[12:10], running[13],
                            // disabled[14], turns_done[30:15], last_turn_ms[62:31], zero[63]

   periodic_turner_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // turner state as predicted
   pts_pkg::mode_type st_mode = pts_pkg::MODE_IDLE;
   logic [31:0] st_last_turn  = '0;
   logic [31:0] st_mode_start = '0;
   logic [15:0] st_turns      = '0;
   logic        st_armed      = 1'b0;
   logic [1:0]  st_dir        = pts_pkg::DIR_OFF;
   logic [7:0]  st_duty       = '0;
   logic [31:0] cfg_interval  = pts_pkg::INTERVAL_RESET;
   logic [31:0] cfg_drive     = pts_pkg::DRIVE_RESET;
   logic [31:0] cfg_pause     = pts_pkg::PAUSE_RESET;
   logic [7:0]  cfg_duty      = pts_pkg::DUTY_RESET;

   status_type status_due[$];
   int      mismatches   = 0;
   int      send_idle    = 0;
   int      recv_stall   = 0;
   int      hold_ticket  = 0;
   int      hold_seen    = 0;
   int      hold_left    = 0;
   int      quiet_cycles = 0;

   function automatic status_type advance_turner(pts_pkg::cmd_type c, logic en,
                                                 logic [31:0] now);
      status_type  s;
      logic [31:0] dt;
      case (c)
         pts_pkg::CMD_UPDATE: begin
            if (!en) begin
               if (st_mode != pts_pkg::MODE_DISABLED) begin
                  st_dir        = pts_pkg::DIR_OFF;
                  st_duty       = '0;
                  st_mode       = pts_pkg::MODE_DISABLED;
                  st_mode_start = now;
               end
               st_armed = 1'b0;
            end else begin
               if (st_mode == pts_pkg::MODE_DISABLED) begin
                  st_mode       = pts_pkg::MODE_IDLE;
                  st_mode_start = now;
                  st_last_turn  = now;
               end
               if (!st_armed) begin
                  st_armed     = 1'b1;
                  st_last_turn = now;
               end
               // idle times from the last turn, every other step from its own start
               dt = now - ((st_mode == pts_pkg::MODE_IDLE) ? st_last_turn : st_mode_start);
               case (st_mode)
                  pts_pkg::MODE_IDLE: if (dt >= cfg_interval) begin
                     st_mode       = pts_pkg::MODE_FORWARD;
                     st_mode_start = now;
                     st_dir        = pts_pkg::DIR_FWD;
                     st_duty       = cfg_duty;
                  end
                  pts_pkg::MODE_FORWARD: if (dt >= cfg_drive) begin
                     st_mode       = pts_pkg::MODE_PAUSE;
                     st_mode_start = now;
                     st_dir        = pts_pkg::DIR_OFF;
                     st_duty       = '0;
                  end
                  pts_pkg::MODE_PAUSE: if (dt >= cfg_pause) begin
                     st_mode       = pts_pkg::MODE_REVERSE;
                     st_mode_start = now;
                     st_dir        = pts_pkg::DIR_REV;
                     st_duty       = cfg_duty;
                  end
                  pts_pkg::MODE_REVERSE: if (dt >= cfg_drive) begin
                     st_mode       = pts_pkg::MODE_IDLE;
                     st_mode_start = now;
                     st_last_turn  = now;
                     st_dir        = pts_pkg::DIR_OFF;
                     st_duty       = '0;
                     st_turns      = st_turns + 16'd1;
                  end
                  default: ;
               endcase
            end
         end
         pts_pkg::CMD_STOP, pts_pkg::CMD_FORCE: begin
            st_dir        = pts_pkg::DIR_OFF;
            st_duty       = '0;
            st_mode       = (c == pts_pkg::CMD_STOP) ? pts_pkg::MODE_IDLE
                                                     : pts_pkg::MODE_DISABLED;
            st_mode_start = now;
         end
         default: ;
      endcase
      s.pin_a     = st_dir[0];
      s.pin_b     = st_dir[1];
      s.duty      = st_duty;
      s.mode      = st_mode;
      s.running   = (st_mode == pts_pkg::MODE_FORWARD) || (st_mode == pts_pkg::MODE_REVERSE);
      s.disabled  = (st_mode == pts_pkg::MODE_DISABLED);
      s.turns     = st_turns;
      s.last_turn = st_last_turn;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 100)
         $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // offer one item; predict on acceptance
   task automatic send_item(pts_pkg::cmd_type c, logic e, logic [31:0] t, logic fixed,
                            status_type want);
      status_type predicted;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {7'd0, t, e};
      do @(posedge clock); while (!req_tready);
      predicted = advance_turner(c, e, t);
      status_due.push_back(fixed ? want : predicted);
   endtask

   // stop offering and wait for every pending result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(pts_pkg::csr_addr_type a, logic [31:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (a)
         pts_pkg::CSR_INTERVAL: cfg_interval = v;
         pts_pkg::CSR_DRIVE:    cfg_drive    = v;
         pts_pkg::CSR_PAUSE:    cfg_pause    = v;
         pts_pkg::CSR_DUTY:     cfg_duty     = v[7:0];
         default: ;
      endcase
   endtask

   function automatic step_type item_row(pts_pkg::cmd_type c, logic e, logic [31:0] t,
                                         logic fixed = 1'b0, status_type want = '0);
      step_type r;
      r       = '0;
      r.cmd   = c;
      r.en    = e;
      r.now   = t;
      r.fixed = fixed;
      r.want  = want;
      return r;
   endfunction

   function automatic step_type csr_row(pts_pkg::csr_addr_type a, logic [31:0] v);
      step_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.addr   = a;
      r.value  = v;
      return r;
   endfunction

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen  <= hold_ticket;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            report_mismatch("item with nothing pending", rsp_tdata[31:0], '0);
         end else begin
            want = status_due.pop_front();
            if (rsp_tdata[0] !== want.pin_a)
               report_mismatch("pin_a", 32'(rsp_tdata[0]), 32'(want.pin_a));
            if (rsp_tdata[1] !== want.pin_b)
               report_mismatch("pin_b", 32'(rsp_tdata[1]), 32'(want.pin_b));
            if (rsp_tdata[9:2] !== want.duty)
               report_mismatch("duty", 32'(rsp_tdata[9:2]), 32'(want.duty));
            if (rsp_tdata[12:10] !== want.mode)
               report_mismatch("mode", 32'(rsp_tdata[12:10]), 32'(want.mode));
            if (rsp_tdata[13] !== want.running)
               report_mismatch("running", 32'(rsp_tdata[13]), 32'(want.running));
            if (rsp_tdata[14] !== want.disabled)
               report_mismatch("disabled", 32'(rsp_tdata[14]), 32'(want.disabled));
            if (rsp_tdata[30:15] !== want.turns)
               report_mismatch("turns_done", 32'(rsp_tdata[30:15]), 32'(want.turns));
            if (rsp_tdata[62:31] !== want.last_turn)
               report_mismatch("last_turn_ms", rsp_tdata[62:31], want.last_turn);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("periodic_turner_sequencer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      step_type         script[$];
      pts_pkg::cmd_type c;
      logic             e;
      logic [31:0]      t;
      logic [31:0]      clk_ms;
      logic [31:0]      base;
      logic [31:0]      span;
      int               pick;

      // default limits: full cycle, duty rewritten mid-drive, codes, wrap, disable
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b0, 32'd0, 1'b1,
         status_type'{1'b0, 1'b0, 8'd0, pts_pkg::MODE_DISABLED, 1'b0, 1'b1, 16'd0, 32'd0}));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd100, 1'b1,
         status_type'{1'b0, 1'b0, 8'd0, pts_pkg::MODE_IDLE, 1'b0, 1'b0, 16'd0, 32'd100}));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7200100, 1'b1,
         status_type'{1'b1, 1'b0, 8'd200, pts_pkg::MODE_FORWARD, 1'b1, 1'b0, 16'd0,
                      32'd100}));
      script.push_back(csr_row(pts_pkg::CSR_DUTY, 32'hABCD_01FF));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7205099));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7205100));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7206100));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7211100));
      script.push_back(item_row(pts_pkg::CMD_NONE, 1'b1, 32'd0));
      script.push_back(item_row(pts_pkg::CMD_STOP, 1'b0, 32'd5));
      script.push_back(item_row(pts_pkg::CMD_FORCE, 1'b1, 32'd6));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'hFFFF_FFFF));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd7199999));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b0, 32'd12345));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b0, 32'd12346));
      // zero limits: one step per update
      script.push_back(csr_row(pts_pkg::CSR_INTERVAL, 32'd0));
      script.push_back(csr_row(pts_pkg::CSR_DRIVE, 32'd0));
      script.push_back(csr_row(pts_pkg::CSR_PAUSE, 32'd0));
      script.push_back(csr_row(pts_pkg::CSR_DUTY, 32'd0));
      repeat (4) script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd1));
      // largest limits: only a timestamp one short of a full wrap passes
      script.push_back(csr_row(pts_pkg::CSR_INTERVAL, 32'hFFFF_FFFF));
      script.push_back(csr_row(pts_pkg::CSR_DRIVE, 32'hFFFF_FFFF));
      script.push_back(csr_row(pts_pkg::CSR_PAUSE, 32'hFFFF_FFFF));
      script.push_back(csr_row(pts_pkg::CSR_DUTY, 32'hFFFF_FFFF));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd1));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'd0));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'hFFFF_FFFE));
      script.push_back(item_row(pts_pkg::CMD_UPDATE, 1'b1, 32'hFFFF_FFFF));
      script.push_back(item_row(pts_pkg::CMD_STOP, 1'b1, 32'd77));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr)
            write_reg(script[i].addr, script[i].value);
         else
            send_item(script[i].cmd, script[i].en, script[i].now,
                      script[i].fixed, script[i].want);
      end

      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 2) begin
            write_reg(pts_pkg::CSR_INTERVAL, $urandom);
            write_reg(pts_pkg::CSR_DRIVE, $urandom);
            write_reg(pts_pkg::CSR_PAUSE, $urandom);
         end else begin
            write_reg(pts_pkg::CSR_INTERVAL, $urandom_range(0, 60));
            write_reg(pts_pkg::CSR_DRIVE, $urandom_range(0, 25));
            write_reg(pts_pkg::CSR_PAUSE, $urandom_range(0, 25));
         end
         write_reg(pts_pkg::CSR_DUTY, $urandom);
         case (ph)
            1:       begin send_idle = 64; recv_stall <= 0;  end
            2:       begin send_idle = 0;  recv_stall <= 64; end
            3:       begin send_idle = 26; recv_stall <= 26; end
            default: begin send_idle = 0;  recv_stall <= 0;  end
         endcase
         // one phase runs across the timestamp wrap
         clk_ms = (ph == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 500) : $urandom;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 4 && n == 40) hold_ticket <= hold_ticket + 1;
            if (ph == 4 && n == 90) drain();
            c    = pts_pkg::CMD_UPDATE;
            e    = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)       e = 1'b0;
            else if (pick < 6)  c = pts_pkg::CMD_STOP;
            else if (pick < 8)  c = pts_pkg::CMD_FORCE;
            else if (pick < 10) c = pts_pkg::CMD_NONE;
            if (c != pts_pkg::CMD_UPDATE) e = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               t = clk_ms + $urandom_range(0, 12);
            end else if (pick < 80) begin
               // land on, or one short of, the limit of the current step
               base = (st_mode == pts_pkg::MODE_IDLE) ? st_last_turn : st_mode_start;
               span = (st_mode == pts_pkg::MODE_IDLE)  ? cfg_interval :
                      (st_mode == pts_pkg::MODE_PAUSE) ? cfg_pause : cfg_drive;
               t = base + span - $urandom_range(0, 1);
            end else if (pick < 90) begin
               t = clk_ms + $urandom_range(0, 3000);
            end else begin
               t = $urandom;
            end
            clk_ms = t;
            send_item(c, e, t, 1'b0, '0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("periodic_turner_sequencer verification clean");
      else
         $display("periodic_turner_sequencer verification failed");
      $finish;
   end

endmodule
